[rtl/i2crm_pkg.sv]
// Shared types, constants and table functions for the bus-slave register map.
// Used by the register store, the engine and the top level.

package i2crm_pkg;

    // Map size and derived widths.
    localparam int NUM_REGS = 23;
    localparam int PTR_W    = $clog2(NUM_REGS + 1);
    localparam int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(NUM_REGS);

    // Command codes.
    localparam logic [1:0] CMD_SELECT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_WRITE  = 2'd2;
    localparam logic [1:0] CMD_LOCAL  = 2'd3;

    // Register lengths in bytes for the named registers of the map.
    localparam int LEN_TABLE_SIZE = 23;
    localparam logic [2:0] LEN_TABLE [0:LEN_TABLE_SIZE-1] = '{
        3'd2, 3'd2, 3'd4, 3'd4, 3'd1, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd1, 3'd2, 3'd2, 3'd2
    };

    // One input word.
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  reg_index;
        logic [7:0]  data_byte;
        logic [31:0] local_value;
    } step_t;

    // One result word.
    typedef struct packed {
        logic [7:0] read_byte;
        logic       more;
        logic       select_ok;
    } result_t;

    // Write request into the register store.
    typedef struct packed {
        logic             en;
        logic [PTR_W-1:0] addr;
        logic [31:0]      data;
    } store_wr_t;

    // Length of a register; registers past the table are four bytes long.
    function automatic logic [2:0] reg_len(input logic [PTR_W-1:0] idx);
        logic [4:0] t;
        t = 5'(idx);
        if (t < 5'(LEN_TABLE_SIZE))
            return LEN_TABLE[t];
        return 3'd4;
    endfunction

    // Mask of the bytes that a register of the given length keeps.
    function automatic logic [31:0] len_mask(input logic [2:0] len);
        logic [31:0] m;
        case (len)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Power-up contents of the store, as raw bit patterns.
    function automatic logic [31:0] reg_init(input int idx);
        logic [31:0] v;
        case (idx)
            2:       v = 32'h4672_2953;  // 15498.331
            3:       v = 32'h3E34_2EDC;  // 0.17596
            5:       v = 32'h3F4C_CCCD;  // 0.8
            6:       v = 32'h3C23_D70A;  // 0.01
            8:       v = 32'hC6FF_FE00;  // -32767.0
            9:       v = 32'h46FF_FE00;  // 32767.0
            22:      v = 32'd3000;       // deadband
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

[rtl/i2crm_if.sv]
// Valid/ready channel interfaces for the request and response words.
// Depends on i2crm_pkg for nothing but sits after it in compile order.

interface i2crm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  reg_index;
    logic [7:0]  data_byte;
    logic [31:0] local_value;

    modport source (output valid, command, reg_index, data_byte, local_value, input ready);
    modport sink   (input valid, command, reg_index, data_byte, local_value, output ready);
endinterface

interface i2crm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       more;
    logic       select_ok;

    modport source (output valid, read_byte, more, select_ok, input ready);
    modport sink   (input valid, read_byte, more, select_ok, output ready);
endinterface

[rtl/i2crm_store.sv]
// Register store: one flip-flop word per register, reset to firmware values.
// One write port and one combinational read port. Depends on i2crm_pkg.

module i2crm_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  i2crm_pkg::store_wr_t       wr,
    input  logic [i2crm_pkg::PTR_W-1:0] rd_addr,
    output logic [31:0]                rd_data
);

    logic [31:0] store_reg [0:i2crm_pkg::NUM_REGS-1];

    // Write port; the engine only issues writes to valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < i2crm_pkg::NUM_REGS; i++)
            begin
                store_reg[i] <= i2crm_pkg::reg_init(i);
            end
        end
        else if (wr.en)
        begin
            store_reg[wr.addr[i2crm_pkg::IDX_W-1:0]] <= wr.data;
        end
    end

    // Read port; addresses past the map read as zero.
    assign rd_data = (rd_addr < i2crm_pkg::PTR_END) ?
                     store_reg[rd_addr[i2crm_pkg::IDX_W-1:0]] : 32'h0;

endmodule

[rtl/i2crm_engine.sv]
// Per-word step logic: pointer, byte index and shadow buffer, plus the
// store read address and write request. Depends on i2crm_pkg.

module i2crm_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  i2crm_pkg::step_t            step,
    input  logic [31:0]                 rd_data,
    output logic [i2crm_pkg::PTR_W-1:0] rd_addr,
    output i2crm_pkg::store_wr_t        wr,
    output i2crm_pkg::result_t          result
);

    logic [i2crm_pkg::PTR_W-1:0] pointer_reg, pointer_next;
    logic [1:0]                  byte_index_reg, byte_index_next;
    logic [31:0]                 shadow_reg, shadow_next;

    logic                        ptr_valid;
    logic                        sel_valid;
    logic                        loc_valid;
    logic [2:0]                  len_cur;
    logic [2:0]                  bi_plus;
    logic                        last_byte;
    logic [i2crm_pkg::PTR_W-1:0] ptr_inc;
    logic [31:0]                 shadow_wr;
    logic [i2crm_pkg::PTR_W-1:0] sel_addr;

    assign ptr_valid = pointer_reg < i2crm_pkg::PTR_END;
    assign sel_valid = step.reg_index < 8'(i2crm_pkg::NUM_REGS);
    assign loc_valid = sel_valid;
    assign len_cur   = i2crm_pkg::reg_len(pointer_reg);
    assign bi_plus   = {1'b0, byte_index_reg} + 3'd1;
    assign last_byte = bi_plus >= len_cur;
    assign ptr_inc   = pointer_reg + 1'b1;
    assign sel_addr  = step.reg_index[i2crm_pkg::PTR_W-1:0];

    // Shadow with the incoming write byte merged at the current byte index.
    always_comb
    begin
        shadow_wr = shadow_reg;
        for (int b = 0; b < 4; b++)
        begin
            if (byte_index_reg == 2'(b))
                shadow_wr[8*b +: 8] = step.data_byte;
        end
    end

    // A select snapshots the named register; otherwise the next one is fetched.
    assign rd_addr = (step.command == i2crm_pkg::CMD_SELECT) ? sel_addr : ptr_inc;

    // Next state, store write and result for the word in the input stage.
    always_comb
    begin
        pointer_next     = pointer_reg;
        byte_index_next  = byte_index_reg;
        shadow_next      = shadow_reg;
        wr               = '0;
        result.read_byte = 8'h00;
        result.select_ok = 1'b0;

        case (step.command)
            i2crm_pkg::CMD_SELECT:
            begin
                if (sel_valid)
                begin
                    pointer_next     = sel_addr;
                    byte_index_next  = 2'd0;
                    shadow_next      = rd_data;
                    result.select_ok = 1'b1;
                end
            end
            i2crm_pkg::CMD_READ:
            begin
                if (ptr_valid)
                begin
                    result.read_byte = shadow_reg[8*byte_index_reg +: 8];
                    byte_index_next  = bi_plus[1:0];
                    if (last_byte)
                    begin
                        byte_index_next = 2'd0;
                        pointer_next    = ptr_inc;
                        if (ptr_inc < i2crm_pkg::PTR_END)
                            shadow_next = rd_data;
                    end
                end
            end
            i2crm_pkg::CMD_WRITE:
            begin
                if (ptr_valid)
                begin
                    shadow_next     = shadow_wr;
                    byte_index_next = bi_plus[1:0];
                    if (last_byte)
                    begin
                        wr.en           = 1'b1;
                        wr.addr         = pointer_reg;
                        wr.data         = shadow_wr & i2crm_pkg::len_mask(len_cur);
                        byte_index_next = 2'd0;
                        pointer_next    = ptr_inc;
                        if (ptr_inc < i2crm_pkg::PTR_END)
                            shadow_next = rd_data;
                    end
                end
            end
            i2crm_pkg::CMD_LOCAL:
            begin
                if (loc_valid)
                begin
                    wr.en   = 1'b1;
                    wr.addr = sel_addr;
                    wr.data = step.local_value &
                              i2crm_pkg::len_mask(i2crm_pkg::reg_len(sel_addr));
                end
            end
            default:
            begin
                wr.en = 1'b0;
            end
        endcase

        wr.en       = wr.en & fire;
        result.more = pointer_next < i2crm_pkg::PTR_END;
    end

    // State registers advance only when a word is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_reg    <= i2crm_pkg::PTR_END;
            byte_index_reg <= 2'd0;
            shadow_reg     <= 32'h0;
        end
        else if (fire)
        begin
            pointer_reg    <= pointer_next;
            byte_index_reg <= byte_index_next;
            shadow_reg     <= shadow_next;
        end
    end

endmodule

[rtl/i2c_register_map_slave_unit.sv]
// Top level of the bus-slave register map: input word register, step engine,
// register store and output word register. Depends on i2crm_pkg and i2crm_if.
// An accepted request is held in the input word register, its response in the output word register.
// Throughput: one word per cycle while the response side takes words; each word is one pass through the engine logic.
// Reset: the store takes its firmware values at once, the pointer sits past the end,
// the byte index and shadow clear, and both word registers are empty.

module i2c_register_map_slave_unit (
    input  logic               clk,
    input  logic               rst_n,
    i2crm_req_if.sink          req,
    i2crm_rsp_if.source        rsp
);

    logic                        in_valid_reg;
    i2crm_pkg::step_t            in_word_reg;
    logic                        out_valid_reg;
    i2crm_pkg::result_t          out_word_reg;

    logic                        fire;
    logic [i2crm_pkg::PTR_W-1:0] rd_addr;
    logic [31:0]                 rd_data;
    i2crm_pkg::store_wr_t        wr;
    i2crm_pkg::result_t          result;

    // The engine processes a word whenever the output register can take it.
    assign fire      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || fire;

    // Input word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_word_reg.command     <= req.command;
            in_word_reg.reg_index   <= req.reg_index;
            in_word_reg.data_byte   <= req.data_byte;
            in_word_reg.local_value <= req.local_value;
        end
    end

    i2crm_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .step    (in_word_reg),
        .rd_data (rd_data),
        .rd_addr (rd_addr),
        .wr      (wr),
        .result  (result)
    );

    i2crm_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_word_reg <= result;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_byte = out_word_reg.read_byte;
    assign rsp.more      = out_word_reg.more;
    assign rsp.select_ok = out_word_reg.select_ok;

endmodule
